// ===== sv/ifsau_pkg.sv =====
`default_nettype none

package ifsau_pkg;

    // Default buffer length in bytes
    localparam int BUFFER_BYTES_DEF = 33;

    // Byte codes of the serial stream
    localparam logic [7:0] DOT_BYTE   = 8'h2E;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] KIND_ANGLE = 8'h53;
    localparam logic [7:0] KIND_RATE  = 8'h52;

    // Angle limits in raw units, one turn is 65536
    localparam logic signed [15:0] QUARTER_TURN     = 16'sd16384;
    localparam logic signed [15:0] NEG_QUARTER_TURN = -16'sd16384;
    localparam logic signed [15:0] HALF_TURN_NEG    = 16'sh8000;
    localparam logic signed [15:0] TURN_LIMIT       = 16'sd32767;
    localparam logic signed [15:0] NEG_TURN_LIMIT   = -16'sd32767;

    // Result of one unwrap step
    typedef struct packed {
        logic               take;
        logic signed [15:0] wrap;
        logic signed [31:0] angle;
    } t_unwrap;

endpackage

`default_nettype wire

// ===== sv/ifsau_unwrap.sv =====
`default_nettype none

module ifsau_unwrap (
    input  wire logic signed [15:0] i_prev,
    input  wire logic signed [15:0] i_wrap,
    input  wire logic signed [15:0] i_raw,
    output ifsau_pkg::t_unwrap      o_step
);
    import ifsau_pkg::*;

    logic               fwd;
    logic               bwd;
    logic signed [15:0] wrap_n;

    // Detect a crossing of the half turn in either direction
    assign fwd = (i_prev > QUARTER_TURN) && (i_raw != HALF_TURN_NEG)
                 && (i_raw < NEG_QUARTER_TURN);
    assign bwd = (i_prev < NEG_QUARTER_TURN) && (i_prev != HALF_TURN_NEG)
                 && (i_raw > QUARTER_TURN);

    // Advance the turn count, saturating at the limits
    always_comb begin
        wrap_n = i_wrap;
        if (fwd) begin
            if (i_wrap < TURN_LIMIT) begin
                wrap_n = i_wrap + 16'sd1;
            end
        end else if (bwd) begin
            if (i_wrap > NEG_TURN_LIMIT) begin
                wrap_n = i_wrap - 16'sd1;
            end
        end
    end

    // Build the continuous angle: raw plus turns times 65536
    always_comb begin
        o_step.take  = (i_raw != HALF_TURN_NEG);
        o_step.wrap  = wrap_n;
        o_step.angle = $signed({wrap_n, 16'h0000}) + $signed({{16{i_raw[15]}}, i_raw});
    end

endmodule

`default_nettype wire

// ===== sv/imu_frame_scan_angle_unwrap_core.sv =====
`default_nettype none

// IMU serial frame scanner with angle unwrap.
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one received byte
// per word; bytes fill a buffer of BUFFER_BYTES entries in a local memory.
// Each byte gives no result except the one that fills the buffer. That byte
// starts a scan: the memory is read one address per cycle, registered,
// while an 8-byte window slides over the data, checking for three
// 0x2E bytes in a row and for 0x55 0x53 angle / 0x55 0x52 rate frames.
// A result word on the output channel (o_res_valid / i_res_ready) is
// registered after the scan, drain and finish states, once the output is
// free. From the scan until that hand-off o_rx_ready is low; otherwise one
// byte is taken per cycle, and no byte of a new buffer is taken until the
// result of the last one is registered.
// A result that waits on a stalled receiver does not stop byte collection;
// only the end of the next scan waits for the output register to empty.
// Reset clears the byte position, the turn count, the held angle and rate,
// and the output valid. The buffer memory is not cleared: every entry is
// written before it is read.
module imu_frame_scan_angle_unwrap_core #(
    parameter int BUFFER_BYTES = ifsau_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rx_valid,
    output logic                    o_rx_ready,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic signed [31:0]      o_angle_unwrapped,
    output logic signed [15:0]      o_turn_count,
    output logic signed [15:0]      o_angular_rate,
    output logic                    o_angle_seen,
    output logic                    o_rate_seen,
    output logic                    o_buffer_dropped
);
    import ifsau_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_BYTES - 1);
    localparam logic [ADDR_W-1:0] FIRST_END = ADDR_W'(7);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [ADDR_W-1:0]  r_pos;
    logic [ADDR_W-1:0]  r_addr;
    logic [7:0]         r_mem [BUFFER_BYTES];
    logic [7:0]         r_rd_data;
    logic               r_dv;
    logic [ADDR_W-1:0]  r_didx;
    logic [7:0]         r_win [7];
    logic [1:0]         r_dot_run;
    logic               r_dot_hit;

    // Working copy of the state during a scan
    logic signed [15:0] r_t_wrap;
    logic signed [15:0] r_t_prev;
    logic signed [31:0] r_t_angle;
    logic signed [15:0] r_t_rate;
    logic               r_t_aseen;
    logic               r_t_rseen;

    // Committed state, also the result word
    logic signed [15:0] r_wrap;
    logic signed [15:0] r_prev;
    logic signed [31:0] r_angle;
    logic signed [15:0] r_rate;
    logic               r_aseen;
    logic               r_rseen;
    logic               r_dropped;
    logic               r_res_valid;

    logic               rx_acc;
    logic               last_byte;
    logic               out_free;
    logic               win_full;
    logic               is_sync;
    logic               is_angle;
    logic               is_rate;
    logic signed [15:0] sample;
    t_unwrap            step;

    assign o_rx_ready = (r_state == ST_COLLECT);
    assign rx_acc     = i_rx_valid && o_rx_ready;
    assign last_byte  = rx_acc && (r_pos == LAST_ADDR);
    assign out_free   = !r_res_valid || i_res_ready;

    // Sequence collect, scan and result hand-off
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_COLLECT: begin
                if (last_byte) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_pos   <= '0;
            r_addr  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the write position, wrap at the buffer end
            if (rx_acc) begin
                r_pos <= (r_pos == LAST_ADDR) ? '0 : r_pos + 1'b1;
            end
            // Advance the read address during the scan
            if (r_state == ST_SCAN) begin
                r_addr <= (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            r_dv <= (r_state == ST_SCAN);
        end
    end

    // Buffer memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_mem[r_pos] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_addr];
        r_didx    <= r_addr;
    end

    // Frame decode on the window plus the newest byte
    assign win_full = (r_didx >= FIRST_END);
    assign is_sync  = r_dv && win_full && (r_win[0] == SYNC_BYTE);
    assign is_angle = is_sync && (r_win[1] == KIND_ANGLE);
    assign is_rate  = is_sync && (r_win[1] == KIND_RATE);
    assign sample   = $signed({r_rd_data, r_win[6]});

    ifsau_unwrap u_unwrap (
        .i_prev (r_t_prev),
        .i_wrap (r_t_wrap),
        .i_raw  (sample),
        .o_step (step)
    );

    // Slide the window and update the working state
    always_ff @(posedge i_clk) begin
        if (last_byte) begin
            r_t_wrap  <= r_wrap;
            r_t_prev  <= r_prev;
            r_t_angle <= r_angle;
            r_t_rate  <= r_rate;
            r_t_aseen <= 1'b0;
            r_t_rseen <= 1'b0;
            r_dot_run <= 2'd0;
            r_dot_hit <= 1'b0;
        end else if (r_dv) begin
            for (int j = 0; j < 6; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[6] <= r_rd_data;
            if (r_rd_data == DOT_BYTE) begin
                if (r_dot_run == 2'd2) begin
                    r_dot_hit <= 1'b1;
                end
                if (r_dot_run != 2'd3) begin
                    r_dot_run <= r_dot_run + 2'd1;
                end
            end else begin
                r_dot_run <= 2'd0;
            end
            if (is_angle) begin
                r_t_wrap <= step.wrap;
                if (step.take) begin
                    r_t_angle <= step.angle;
                    r_t_prev  <= sample;
                    r_t_aseen <= 1'b1;
                end
            end
            if (is_rate) begin
                r_t_rate  <= sample;
                r_t_rseen <= 1'b1;
            end
        end
    end

    // Commit the scan, or keep the held values on a dropped buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap      <= '0;
            r_prev      <= '0;
            r_angle     <= '0;
            r_rate      <= '0;
            r_aseen     <= 1'b0;
            r_rseen     <= 1'b0;
            r_dropped   <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (r_state == ST_FINISH && out_free) begin
            r_res_valid <= 1'b1;
            r_dropped   <= r_dot_hit;
            r_aseen     <= !r_dot_hit && r_t_aseen;
            r_rseen     <= !r_dot_hit && r_t_rseen;
            if (!r_dot_hit) begin
                r_wrap  <= r_t_wrap;
                r_prev  <= r_t_prev;
                r_angle <= r_t_angle;
                r_rate  <= r_t_rate;
            end
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_angle_unwrapped = r_angle;
    assign o_turn_count      = r_wrap;
    assign o_angular_rate    = r_rate;
    assign o_angle_seen      = r_aseen;
    assign o_rate_seen       = r_rseen;
    assign o_buffer_dropped  = r_dropped;

`ifndef SYNTHESIS
    a_scan_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_pos == '0))
        else $error("write position not rewound during scan");

    a_new_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result raised outside finish");

    a_drop_clears_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_buffer_dropped) |-> (!o_angle_seen && !o_rate_seen))
        else $error("dropped buffer reports a frame");

    a_turn_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_turn_count != HALF_TURN_NEG))
        else $error("turn count left saturation range");

    a_last_read_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_dv && (r_didx == LAST_ADDR)))
        else $error("drain without last buffer byte");
`endif

endmodule

`default_nettype wire
